### src/ecpg_pkg.sv
// Shared types and constants of the ellipse column point generator.
package ecpg_pkg;

  localparam int unsigned CoordW  = 8;
  localparam int unsigned GridW   = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SqW     = 16;
  localparam int unsigned RhsW    = 34;
  localparam int unsigned OddMulW = 17;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_GRID  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_RADIUS_X    = 3'd2,
    CFG_RADIUS_Y    = 3'd3,
    CFG_GRID_WIDTH  = 3'd4,
    CFG_GRID_HEIGHT = 3'd5
  } cfg_idx_e;

  // Item moving through the half-height search.
  typedef struct packed {
    logic [CoordW-1:0] dx;
    status_e           status;
    logic [RhsW-1:0]   rhs;
    logic [CoordW-1:0] dy;
  } srch_t;

  // Item handed to the point emitter.
  typedef struct packed {
    logic [CoordW-1:0] xp;
    logic [CoordW-1:0] xm;
    logic [CoordW-1:0] yp;
    logic [CoordW-1:0] ym;
    logic              dx_nz;
    logic              dy_nz;
    status_e           status;
  } emit_t;

endpackage

### src/ecpg_if.sv
// Channel interfaces: column offsets in, points out, register writes.
interface ecpg_in_if import ecpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] column_offset;

  modport source (output valid, output column_offset, input ready);
  modport sink   (input valid, input column_offset, output ready);
endinterface

interface ecpg_out_if import ecpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] point_x;
  logic [CoordW-1:0] point_y;
  logic [1:0]        status;
  logic              last_point;

  modport source (output valid, output point_x, output point_y, output status,
                  output last_point, input ready);
  modport sink   (input valid, input point_x, input point_y, input status,
                  input last_point, output ready);
endinterface

interface ecpg_cfg_if import ecpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [GridW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/ecpg_search_step.sv
// One bit of the half-height search: odd multiple of rx, then square and compare.
module ecpg_search_step import ecpg_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  srch_t             item_i,
  input  logic [CoordW-1:0] radius_x_i,
  input  logic [CoordW-1:0] radius_y_i,
  output logic              valid_o,
  output srch_t             item_o
);

  localparam logic [CoordW-1:0] BitMask = CoordW'(1 << BIT);

  logic [CoordW-1:0]  cand;
  logic [CoordW:0]    odd;
  logic [OddMulW-1:0] odd_rx;
  logic [RhsW-1:0]    sq;
  logic               take;
  srch_t              item_d;

  logic               mid_valid_q;
  srch_t              mid_item_q;
  logic [OddMulW-1:0] mid_m_q;
  logic               mid_ok_q;
  logic               valid_q;
  srch_t              item_q;

  // Try setting this bit of dy: candidate must stay within ry.
  always_comb begin
    cand   = item_i.dy | BitMask;
    odd    = {cand, 1'b0} - (CoordW+1)'(1);
    odd_rx = OddMulW'({8'b0, odd} * {9'b0, radius_x_i});
  end

  // Keep the bit when the squared odd multiple stays within the bound.
  always_comb begin
    sq     = RhsW'({17'b0, mid_m_q} * {17'b0, mid_m_q});
    take   = mid_ok_q && (sq <= mid_item_q.rhs);
    item_d = mid_item_q;
    if (take) begin
      item_d.dy = mid_item_q.dy | BitMask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      valid_q     <= 1'b0;
    end else if (en_i) begin
      mid_valid_q <= valid_i;
      valid_q     <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_item_q <= item_i;
      mid_m_q    <= odd_rx;
      mid_ok_q   <= (cand <= radius_y_i);
      item_q     <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### src/ecpg_emitter.sv
// Holds one column's mirrored points and sends them out one per transfer.
module ecpg_emitter import ecpg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  emit_t        item_i,
  output logic         take_o,
  ecpg_out_if.source   pt_o
);

  logic        vld_q;
  logic [1:0]  seq_q;
  emit_t       item_q;
  logic [3:0]  pres;
  logic [3:0]  later;
  logic [1:0]  nxt;
  logic        last;

  // Point order: (xp,yp) (xp,ym) (xm,yp) (xm,ym); skip copies on a zero offset.
  always_comb begin
    pres  = {item_q.dx_nz & item_q.dy_nz, item_q.dx_nz, item_q.dy_nz, 1'b1};
    later = pres & (4'b1110 << seq_q);
    last  = (later == 4'b0000);
    nxt   = seq_q;
    for (int i = 3; i >= 0; i--) begin
      if (later[i]) begin
        nxt = 2'(i);
      end
    end
  end

  assign take_o = !vld_q || (pt_o.ready && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      seq_q <= 2'd0;
    end else if (take_o) begin
      vld_q <= load_i;
      seq_q <= 2'd0;
    end else if (pt_o.ready) begin
      seq_q <= nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && load_i) begin
      item_q <= item_i;
    end
  end

  assign pt_o.valid      = vld_q;
  assign pt_o.point_x    = seq_q[1] ? item_q.xm : item_q.xp;
  assign pt_o.point_y    = seq_q[0] ? item_q.ym : item_q.yp;
  assign pt_o.status     = item_q.status;
  assign pt_o.last_point = last;

endmodule

### src/ellipse_column_point_generator.sv
// Top level: ellipse column rasterizer, half-height search pipeline and point emitter.
//
//   channel | dir | payload                                    | transfer when
//   cfg_i   | in  | index (3b), data (9b)                      | valid & ready (ready tied high)
//   col_i   | in  | column_offset (8b)                         | valid & ready
//   pt_o    | out | point_x, point_y (8b), status (2b), last   | valid & ready
//
// From a column transfer to its first point: three stages build 4*ry^2*(rx^2-dx^2),
// sixteen stages resolve dy one bit per two stages, and the emitter register presents
// the points. A column yields 1 to 4 points on pt_o, so the emitter sets the sustained
// rate; a new column enters on the edge at which the emitter sends the last point of
// the column it holds.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// While the emitter holds a column that is not finishing, every stage holds.
module ellipse_column_point_generator import ecpg_pkg::*; #(
  parameter int unsigned GRID_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ecpg_cfg_if.sink   cfg_i,
  ecpg_in_if.sink    col_i,
  ecpg_out_if.source pt_o
);

  localparam int unsigned NumBits = CoordW;

  // Configuration registers
  logic [CoordW-1:0] center_x_q, center_y_q, radius_x_q, radius_y_q;
  logic [GridW-1:0]  grid_width_q, grid_height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= '0;
      center_y_q    <= '0;
      radius_x_q    <= CoordW'(1);
      radius_y_q    <= CoordW'(1);
      grid_width_q  <= GridW'(256);
      grid_height_q <= GridW'(256);
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_CENTER_X:    center_x_q    <= cfg_i.data[CoordW-1:0];
        CFG_CENTER_Y:    center_y_q    <= cfg_i.data[CoordW-1:0];
        CFG_RADIUS_X:    radius_x_q    <= cfg_i.data[CoordW-1:0];
        CFG_RADIUS_Y:    radius_y_q    <= cfg_i.data[CoordW-1:0];
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_i.data;
        CFG_GRID_HEIGHT: grid_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves whenever the emitter can take its output.
  logic en;
  logic emit_take;

  assign en          = emit_take;
  assign col_i.ready = en;

  // Entry checks: grid fit first, then offset range.
  logic    grid_bad;
  status_e in_status;

  always_comb begin
    grid_bad = (radius_x_q == '0)
            || (32'(grid_width_q) > 32'(GRID_SIZE))
            || (32'(grid_height_q) > 32'(GRID_SIZE))
            || (({1'b0, center_x_q} + {1'b0, radius_x_q}) >= grid_width_q)
            || (({1'b0, center_y_q} + {1'b0, radius_y_q}) >= grid_height_q)
            || (center_x_q < radius_x_q)
            || (center_y_q < radius_y_q);
    if (grid_bad) begin
      in_status = ST_GRID;
    end else if (col_i.column_offset > radius_x_q) begin
      in_status = ST_RANGE;
    end else begin
      in_status = ST_OK;
    end
  end

  // Stage A: squares
  logic              a_valid_q;
  logic [CoordW-1:0] a_dx_q;
  status_e           a_status_q;
  logic [SqW-1:0]    a_dx2_q, a_rx2_q, a_ry2_q;

  // Stage B: rx^2 - dx^2
  logic              b_valid_q;
  logic [CoordW-1:0] b_dx_q;
  status_e           b_status_q;
  logic [SqW-1:0]    b_s_q, b_ry2_q;

  // Stage C: right-hand side of the half-height test
  logic              c_valid_q;
  srch_t             c_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= col_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q     <= col_i.column_offset;
      a_status_q <= in_status;
      a_dx2_q    <= SqW'({8'b0, col_i.column_offset} * {8'b0, col_i.column_offset});
      a_rx2_q    <= SqW'({8'b0, radius_x_q} * {8'b0, radius_x_q});
      a_ry2_q    <= SqW'({8'b0, radius_y_q} * {8'b0, radius_y_q});

      b_dx_q     <= a_dx_q;
      b_status_q <= a_status_q;
      // Only an in-range offset needs a meaningful difference.
      b_s_q      <= (a_status_q == ST_OK) ? (a_rx2_q - a_dx2_q) : '0;
      b_ry2_q    <= a_ry2_q;

      c_item_q.dx     <= b_dx_q;
      c_item_q.status <= b_status_q;
      c_item_q.rhs    <= {32'({16'b0, b_ry2_q} * {16'b0, b_s_q}), 2'b00};
      c_item_q.dy     <= '0;
    end
  end

  // Half-height search, most significant bit first.
  logic  srch_valid [NumBits+1];
  srch_t srch_item  [NumBits+1];

  assign srch_valid[0] = c_valid_q;
  assign srch_item[0]  = c_item_q;

  for (genvar g = 0; g < NumBits; g++) begin : g_step
    ecpg_search_step #(
      .BIT (NumBits - 1 - g)
    ) u_step (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (srch_valid[g]),
      .item_i     (srch_item[g]),
      .radius_x_i (radius_x_q),
      .radius_y_i (radius_y_q),
      .valid_o    (srch_valid[g+1]),
      .item_o     (srch_item[g+1])
    );
  end

  // Mirror the point around the centre; an error carries zero coordinates.
  srch_t fin;
  emit_t emit_item;

  assign fin = srch_item[NumBits];

  always_comb begin
    emit_item.status = fin.status;
    if (fin.status == ST_OK) begin
      emit_item.xp    = center_x_q + fin.dx;
      emit_item.xm    = center_x_q - fin.dx;
      emit_item.yp    = center_y_q + fin.dy;
      emit_item.ym    = center_y_q - fin.dy;
      emit_item.dx_nz = (fin.dx != '0);
      emit_item.dy_nz = (fin.dy != '0);
    end else begin
      emit_item.xp    = '0;
      emit_item.xm    = '0;
      emit_item.yp    = '0;
      emit_item.ym    = '0;
      emit_item.dx_nz = 1'b0;
      emit_item.dy_nz = 1'b0;
    end
  end

  ecpg_emitter u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (srch_valid[NumBits]),
    .item_i (emit_item),
    .take_o (emit_take),
    .pt_o   (pt_o)
  );

  // An error column is a single item with zero coordinates.
  a_err_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_o.valid && (pt_o.status != ST_OK)) |->
      (pt_o.last_point && (pt_o.point_x == '0) && (pt_o.point_y == '0)))
    else $error("error item malformed");

  // The search never settles above the vertical radius.
  a_dy_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_valid[NumBits] |-> (fin.dy <= radius_y_q))
    else $error("half height above radius");

  // A valid point stays inside the ellipse's bounding rows.
  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_o.valid && (pt_o.status == ST_OK)) |->
      ({1'b0, pt_o.point_y} <= ({1'b0, center_y_q} + {1'b0, radius_y_q}))
      && ({1'b0, pt_o.point_y} >= ({1'b0, center_y_q} - {1'b0, radius_y_q})))
    else $error("point row outside ellipse");

  // A held stage keeps its valid bit while the emitter is busy.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(c_valid_q))
    else $error("pipeline moved during hold");

endmodule
